>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules of the peak tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is high.
`define MDPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define MDPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mdpt_pkg.sv
// Package with the payload types, widths and hold-back table of the peak tracker.
package mdpt_pkg;

   localparam int ACT_W           = 18;
   localparam int WGT_W           = 8;
   localparam int RANK_W          = 6;
   localparam int PROD_W          = ACT_W + WGT_W;
   localparam int SUM_W           = 43;
   localparam int PEAK_W          = 42;
   localparam int HELD_W          = 7;
   localparam int OUT_FIELDS      = 5;
   // One running sum and one peak per entry of the hold-back table below.
   localparam int CANDIDATE_COUNT = 5;

   typedef struct packed {
      logic signed [ACT_W-1:0] act_value;
      logic signed [WGT_W-1:0] weight_value;
      logic [RANK_W-1:0]       outlier_rank;
      logic                    row_end;
      logic                    set_end;
   } req_payload_type;

   typedef struct packed {
      logic [PEAK_W-1:0] peak_none_held;
      logic [PEAK_W-1:0] peak_four_held;
      logic [PEAK_W-1:0] peak_eight_held;
      logic [PEAK_W-1:0] peak_sixteen_held;
      logic [PEAK_W-1:0] peak_thirtytwo_held;
   } rsp_payload_type;

   // Control bits that travel with an element through the pipeline.
   typedef struct packed {
      logic valid;
      logic row_end;
      logic set_end;
   } stage_ctl_type;

   // Number of top-ranked channels held back for a candidate sum.
   function automatic logic [HELD_W-1:0] held_count(input int idx, input int max_held);
      logic [HELD_W-1:0] cnt;
      case (idx)
         0: begin
            cnt = HELD_W'(0);
         end
         1: begin
            cnt = HELD_W'(4);
         end
         2: begin
            cnt = HELD_W'(8);
         end
         3: begin
            cnt = HELD_W'(16);
         end
         default: begin
            cnt = HELD_W'(max_held);
         end
      endcase
      return cnt;
   endfunction

endpackage

>>> hw/rtl/masked_dot_peak_tracker.sv
// Masked dot product peak tracker: one element pair per cycle, peaks for five hold-back counts.
// The result of a set appears on rsp_valid once its set_end element has passed the input
// register, multiply stage, accumulate stage and result register.
// The block takes one element pair per cycle; the pipeline holds only while a finished result
// waits and the next set_end element reaches the peak stage.
// Reset clears pipeline control, running sums and peaks at once; no clearing pass.
module masked_dot_peak_tracker #(
   parameter int MAX_HELD        = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mdpt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mdpt_pkg::rsp_payload_type rsp_payload
);

   logic en;
   mdpt_pkg::stage_ctl_type prod_ctl;
   logic signed [mdpt_pkg::PROD_W-1:0] prod_value;
   logic [mdpt_pkg::CANDIDATE_COUNT-1:0] prod_mask;
   mdpt_pkg::stage_ctl_type row_ctl;
   logic signed [mdpt_pkg::SUM_W-1:0] row_sum [mdpt_pkg::CANDIDATE_COUNT];

   // The whole pipeline advances together unless a new result would overwrite a waiting one.
   assign en        = ~(row_ctl.valid & row_ctl.set_end & rsp_valid & ~rsp_ready);
   assign req_ready = en;

   mdpt_mult #(
      .MAX_HELD       (MAX_HELD)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .prod_ctl   (prod_ctl),
      .prod_value (prod_value),
      .prod_mask  (prod_mask)
   );

   mdpt_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .prod_ctl  (prod_ctl),
      .prod_value(prod_value),
      .prod_mask (prod_mask),
      .row_ctl   (row_ctl),
      .row_sum   (row_sum)
   );

   mdpt_peak u_peak (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .row_ctl    (row_ctl),
      .row_sum    (row_sum),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

>>> hw/rtl/mdpt_mult.sv
// Input register, product and per-candidate inclusion mask of the peak tracker.
module mdpt_mult #(
   parameter int MAX_HELD        = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          req_valid,
   input  mdpt_pkg::req_payload_type     req_payload,
   output mdpt_pkg::stage_ctl_type       prod_ctl,
   output logic signed [mdpt_pkg::PROD_W-1:0] prod_value,
   output logic [mdpt_pkg::CANDIDATE_COUNT-1:0] prod_mask
);

   mdpt_pkg::stage_ctl_type   in_ctl_ff, in_ctl_in;
   mdpt_pkg::req_payload_type in_pay_ff, in_pay_in;
   mdpt_pkg::stage_ctl_type   prod_ctl_ff, prod_ctl_in;
   logic signed [mdpt_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mdpt_pkg::CANDIDATE_COUNT-1:0] mask_ff, mask_in;
   logic signed [mdpt_pkg::PROD_W-1:0] act_ext, wgt_ext;

   always_comb begin
      in_ctl_in = in_ctl_ff;
      in_pay_in = in_pay_ff;
      if (en) begin
         in_ctl_in.valid   = req_valid;
         // The end of the set also closes the dot product in progress.
         in_ctl_in.row_end = req_payload.row_end | req_payload.set_end;
         in_ctl_in.set_end = req_payload.set_end;
         in_pay_in         = req_payload;
      end
   end

   assign act_ext = {{mdpt_pkg::WGT_W{in_pay_ff.act_value[mdpt_pkg::ACT_W-1]}},
                     in_pay_ff.act_value};
   assign wgt_ext = {{mdpt_pkg::ACT_W{in_pay_ff.weight_value[mdpt_pkg::WGT_W-1]}},
                     in_pay_ff.weight_value};

   always_comb begin
      prod_ctl_in = prod_ctl_ff;
      prod_in     = prod_ff;
      mask_in     = mask_ff;
      if (en) begin
         prod_ctl_in = in_ctl_ff;
         prod_in     = act_ext * wgt_ext;
         for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
            mask_in[i] = {1'b0, in_pay_ff.outlier_rank} >= mdpt_pkg::held_count(i, MAX_HELD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff   <= '0;
         prod_ctl_ff <= '0;
      end else begin
         in_ctl_ff   <= in_ctl_in;
         prod_ctl_ff <= prod_ctl_in;
      end
      in_pay_ff <= in_pay_in;
      prod_ff   <= prod_in;
      mask_ff   <= mask_in;
   end

   assign prod_ctl   = prod_ctl_ff;
   assign prod_value = prod_ff;
   assign prod_mask  = mask_ff;

endmodule

>>> hw/rtl/mdpt_accum.sv
// Saturating running sums, one per candidate, closed out at the end of each dot product.
module mdpt_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  mdpt_pkg::stage_ctl_type       prod_ctl,
   input  logic signed [mdpt_pkg::PROD_W-1:0] prod_value,
   input  logic [mdpt_pkg::CANDIDATE_COUNT-1:0] prod_mask,
   output mdpt_pkg::stage_ctl_type       row_ctl,
   output logic signed [mdpt_pkg::SUM_W-1:0] row_sum [mdpt_pkg::CANDIDATE_COUNT]
);

   logic signed [mdpt_pkg::SUM_W-1:0] sum_ff [mdpt_pkg::CANDIDATE_COUNT];
   logic signed [mdpt_pkg::SUM_W-1:0] sum_in [mdpt_pkg::CANDIDATE_COUNT];
   logic signed [mdpt_pkg::SUM_W-1:0] row_ff [mdpt_pkg::CANDIDATE_COUNT];
   logic signed [mdpt_pkg::SUM_W-1:0] row_in [mdpt_pkg::CANDIDATE_COUNT];
   logic signed [mdpt_pkg::SUM_W-1:0] sum_next [mdpt_pkg::CANDIDATE_COUNT];
   logic signed [mdpt_pkg::SUM_W:0]   sum_wide [mdpt_pkg::CANDIDATE_COUNT];
   mdpt_pkg::stage_ctl_type row_ctl_ff, row_ctl_in;

   always_comb begin
      for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
         sum_wide[i] = {sum_ff[i][mdpt_pkg::SUM_W-1], sum_ff[i]};
         if (prod_mask[i]) begin
            sum_wide[i] = sum_wide[i] +
               {{(mdpt_pkg::SUM_W + 1 - mdpt_pkg::PROD_W){prod_value[mdpt_pkg::PROD_W-1]}},
                prod_value};
         end
         // The top two bits differ only when the sum has left the 43-bit range.
         if (sum_wide[i][mdpt_pkg::SUM_W] != sum_wide[i][mdpt_pkg::SUM_W-1]) begin
            sum_next[i] = sum_wide[i][mdpt_pkg::SUM_W] ?
               {1'b1, {(mdpt_pkg::SUM_W-1){1'b0}}} : {1'b0, {(mdpt_pkg::SUM_W-1){1'b1}}};
         end else begin
            sum_next[i] = sum_wide[i][mdpt_pkg::SUM_W-1:0];
         end
      end
   end

   always_comb begin
      row_ctl_in = row_ctl_ff;
      sum_in     = sum_ff;
      row_in     = row_ff;
      if (en) begin
         row_ctl_in       = prod_ctl;
         row_ctl_in.valid = prod_ctl.valid & prod_ctl.row_end;
         if (prod_ctl.valid) begin
            row_in = sum_next;
            for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
               sum_in[i] = prod_ctl.row_end ? '0 : sum_next[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ctl_ff <= '0;
         for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         row_ctl_ff <= row_ctl_in;
         sum_ff     <= sum_in;
      end
      row_ff <= row_in;
   end

   assign row_ctl = row_ctl_ff;
   assign row_sum = row_ff;

endmodule

>>> hw/rtl/mdpt_peak.sv
// Peak magnitude tracking per candidate and the result register.
`include "assert_macros.svh"

module mdpt_peak (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  mdpt_pkg::stage_ctl_type       row_ctl,
   input  logic signed [mdpt_pkg::SUM_W-1:0] row_sum [mdpt_pkg::CANDIDATE_COUNT],
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mdpt_pkg::rsp_payload_type     rsp_payload
);

   logic [mdpt_pkg::PEAK_W-1:0] peak_ff [mdpt_pkg::CANDIDATE_COUNT];
   logic [mdpt_pkg::PEAK_W-1:0] peak_in [mdpt_pkg::CANDIDATE_COUNT];
   logic [mdpt_pkg::PEAK_W-1:0] peak_next [mdpt_pkg::CANDIDATE_COUNT];
   logic [mdpt_pkg::SUM_W-1:0]  mag [mdpt_pkg::CANDIDATE_COUNT];
   logic [mdpt_pkg::PEAK_W-1:0] out_arr [mdpt_pkg::OUT_FIELDS];
   mdpt_pkg::rsp_payload_type   rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        row_take;

   assign row_take = en & row_ctl.valid;

   always_comb begin
      for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
         mag[i] = row_sum[i][mdpt_pkg::SUM_W-1] ? (~row_sum[i] + 1'b1) : row_sum[i];
         peak_next[i] = peak_ff[i];
         // Only the most negative sum has a magnitude above the peak range.
         if (mag[i][mdpt_pkg::SUM_W-1]) begin
            peak_next[i] = '1;
         end else if (mag[i][mdpt_pkg::PEAK_W-1:0] > peak_ff[i]) begin
            peak_next[i] = mag[i][mdpt_pkg::PEAK_W-1:0];
         end
      end
      for (int i = 0; i < mdpt_pkg::OUT_FIELDS; i++) begin
         if (i < mdpt_pkg::CANDIDATE_COUNT) begin
            out_arr[i] = peak_next[i];
         end else begin
            out_arr[i] = '0;
         end
      end
   end

   always_comb begin
      peak_in      = peak_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (row_take) begin
         for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
            peak_in[i] = row_ctl.set_end ? '0 : peak_next[i];
         end
         if (row_ctl.set_end) begin
            rsp_valid_in                    = 1'b1;
            rsp_in.peak_none_held      = out_arr[0];
            rsp_in.peak_four_held      = out_arr[1];
            rsp_in.peak_eight_held     = out_arr[2];
            rsp_in.peak_sixteen_held   = out_arr[3];
            rsp_in.peak_thirtytwo_held = out_arr[4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < mdpt_pkg::CANDIDATE_COUNT; i++) begin
            peak_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MDPT_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid_ff, "result valid right after reset")
   `MDPT_ASSERT(a_emit_clears_peak, clock, reset, (row_take && row_ctl.set_end) |=> (peak_ff[0] == '0), "peak not cleared after a result")
   `MDPT_ASSERT(a_peak_monotonic, clock, reset, (row_take && !row_ctl.set_end) |=> (peak_ff[0] >= $past(peak_ff[0])), "peak dropped within a set")
   `MDPT_ASSERT(a_emit_sets_valid, clock, reset, (row_take && row_ctl.set_end) |=> rsp_valid_ff, "result lost at end of set")

endmodule
